// ----- rtl/eml_pkg.sv -----
// ----------------------------------------------------------------------------
// eml_pkg
// Shared types and constants of the extent map lookup block.
// ----------------------------------------------------------------------------
package eml_pkg;

  localparam int SLOT_W = 8;
  localparam int POS_W  = 63;
  localparam int LEN_W  = 31;
  localparam int BASE_W = 32;
  localparam int MODE_W = 3;

  localparam int IN_TDATA_W  = 304;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_TUSER_W = 1;

  localparam logic [SLOT_W-1:0] EMPTY_SLOT = 8'hFF;
  localparam logic [SLOT_W-1:0] FIRST_STEP = 8'h80;

  localparam logic [MODE_W-1:0] MODE_LOAD_EXT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_ORD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET_SIZE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY_RD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY_WR = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD_EXT,
    OP_LOAD_ORD,
    OP_SET_SIZE,
    OP_QUERY_RD,
    OP_QUERY_WR
  } op_t;

  // One classified item as it waits between the front and the back.
  // pos carries load_start, new_size or query_pos; len carries
  // load_length or query_size.
  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] order;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [BASE_W-1:0] base;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PRB_ORD,
    ST_PRB_EXT,
    ST_FIN_CNT,
    ST_FIN_END,
    ST_FIN_UPD,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/eml_front.sv -----
// ----------------------------------------------------------------------------
// eml_front
// Accepts input items, decodes the mode into an operation, turns loads that
// fall outside the tables into no-ops, and queues the items for the back end.
// ----------------------------------------------------------------------------
module eml_front #(
  parameter int EXTENT_ENTRIES = 240,
  parameter int ORDER_SLOTS    = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [eml_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [eml_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                           q_valid,
  output eml_pkg::cmd_t                  q_cmd,
  input  logic                           q_pop
);
  import eml_pkg::*;

  cmd_t       cmd_in;
  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.slot  = in_tdata[7:0];
    cmd_in.order = in_tdata[141:134];
    cmd_in.base  = in_tdata[133:102];
    cmd_in.pos   = in_tdata[70:8];
    cmd_in.len   = in_tdata[101:71];
    cmd_in.op    = OP_NOP;
    unique case (in_tuser)
      MODE_LOAD_EXT: begin
        if ({1'b0, in_tdata[7:0]} < 9'(EXTENT_ENTRIES)) begin
          cmd_in.op = OP_LOAD_EXT;
        end
      end
      MODE_LOAD_ORD: begin
        if ({1'b0, in_tdata[7:0]} < 9'(ORDER_SLOTS)) begin
          cmd_in.op = OP_LOAD_ORD;
        end
      end
      MODE_SET_SIZE: begin
        cmd_in.op  = OP_SET_SIZE;
        cmd_in.pos = in_tdata[204:142];
      end
      MODE_QUERY_RD: begin
        cmd_in.op  = OP_QUERY_RD;
        cmd_in.pos = in_tdata[267:205];
        cmd_in.len = in_tdata[298:268];
      end
      MODE_QUERY_WR: begin
        cmd_in.op  = OP_QUERY_WR;
        cmd_in.pos = in_tdata[267:205];
        cmd_in.len = in_tdata[298:268];
      end
      default: begin
        cmd_in.op = OP_NOP;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- rtl/eml_back.sv -----
// ----------------------------------------------------------------------------
// eml_back
// Holds the extent table and the sorted slot table, carries out loads and
// runs the binary probe for queries, then forms the result item.
// ----------------------------------------------------------------------------
module eml_back #(
  parameter int EXTENT_ENTRIES = 240,
  parameter int ORDER_SLOTS    = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  eml_pkg::cmd_t                   q_cmd,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [eml_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [eml_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import eml_pkg::*;

  localparam int EW = (EXTENT_ENTRIES > 1) ? $clog2(EXTENT_ENTRIES) : 1;
  localparam int OW = $clog2(ORDER_SLOTS);

  typedef struct packed {
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic [BASE_W-1:0] base;
  } ext_t;

  ext_t              ext_mem [EXTENT_ENTRIES];
  ext_t              ext_rdata_r;
  logic [SLOT_W-1:0] ord_mem [ORDER_SLOTS];
  logic              ord_vld_r [ORDER_SLOTS];
  logic [SLOT_W-1:0] ord_rdata_r;
  logic              ord_rvld_r;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [SLOT_W-1:0] curr_r, step_r, e_r;
  logic [63:0]       fsub_r;
  logic [LEN_W-1:0]  size_r;
  logic              found_r;
  logic [SLOT_W-1:0] spos_r, ext_r;
  logic [LEN_W-1:0]  diff_r, len_r, count_r;
  logic [BASE_W-1:0] base_r, addr_r;
  logic [POS_W-1:0]  end_r, fsize_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_spos_r, out_ext_r;
  logic [BASE_W-1:0] out_addr_r;
  logic [LEN_W-1:0]  out_count_r;
  logic [POS_W-1:0]  out_fsize_r;

  logic              is_query;
  logic [SLOT_W-1:0] probe_slot, step_half, curr_adv, ord_e;
  logic              ord_use, last_step;
  logic              ext_ge, ext_in;
  logic [POS_W-1:0]  ext_d;
  logic              out_free;
  logic [LEN_W-1:0]  avail, size_clip;
  logic [63:0]       end_sum;

  logic              ord_ren, ext_ren, out_load;
  logic [SLOT_W-1:0] ord_raddr;

  assign is_query   = (q_cmd.op == OP_QUERY_RD) || (q_cmd.op == OP_QUERY_WR);
  assign probe_slot = curr_r + step_r;
  assign step_half  = {1'b0, step_r[SLOT_W-1:1]};
  assign last_step  = (step_r == '0);
  assign ord_e      = ord_rvld_r ? ord_rdata_r : EMPTY_SLOT;
  assign ord_use    = ({1'b0, ord_e} < 9'(EXTENT_ENTRIES));
  assign ext_ge     = (cmd_r.pos >= ext_rdata_r.start);
  assign ext_d      = cmd_r.pos - ext_rdata_r.start;
  assign ext_in     = ext_ge && (ext_d[POS_W-1:LEN_W] == '0)
                      && (ext_d[LEN_W-1:0] < ext_rdata_r.length);
  assign curr_adv   = ext_ge ? probe_slot : curr_r;
  assign out_free   = !out_valid_r || out_tready;
  assign avail      = len_r - diff_r;
  assign end_sum    = {1'b0, cmd_r.pos} + 64'(count_r);

  // Reads are cut to what is left before the end of the file.
  always_comb begin
    size_clip = cmd_r.len;
    if (cmd_r.op == OP_QUERY_RD) begin
      if (fsub_r[63] || (fsub_r == '0)) begin
        size_clip = '0;
      end else if ((fsub_r[62:LEN_W] == '0) && (fsub_r[LEN_W-1:0] < cmd_r.len)) begin
        size_clip = fsub_r[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = is_query ? ST_PRB_ORD : ST_LOAD;
        end
      end
      ST_LOAD:    state_nxt = ST_OUT;
      ST_PRB_ORD: begin
        if (ord_use) begin
          state_nxt = ST_PRB_EXT;
        end else if (last_step) begin
          state_nxt = ST_FIN_CNT;
        end
      end
      ST_PRB_EXT: begin
        if (ext_in || last_step) begin
          state_nxt = ST_FIN_CNT;
        end else begin
          state_nxt = ST_PRB_ORD;
        end
      end
      ST_FIN_CNT: state_nxt = ST_FIN_END;
      ST_FIN_END: state_nxt = ST_FIN_UPD;
      ST_FIN_UPD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ord_ren   = 1'b0;
    ord_raddr = FIRST_STEP;
    ext_ren   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop   = q_valid;
        ord_ren = q_valid && is_query;
      end
      ST_PRB_ORD: begin
        ext_ren   = ord_use;
        ord_ren   = !ord_use && !last_step;
        ord_raddr = curr_r + step_half;
      end
      ST_PRB_EXT: begin
        ord_ren   = !ext_in && !last_step;
        ord_raddr = curr_adv + step_half;
      end
      ST_OUT: begin
        out_load = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Table storage: one write and one registered read per table.
  always_ff @(posedge clk) begin
    if ((state_r == ST_LOAD) && (cmd_r.op == OP_LOAD_EXT)) begin
      ext_mem[cmd_r.slot[EW-1:0]] <= '{start: cmd_r.pos, length: cmd_r.len,
                                        base: cmd_r.base};
    end
    if (ext_ren) begin
      ext_rdata_r <= ext_mem[ord_e[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_LOAD) && (cmd_r.op == OP_LOAD_ORD)) begin
      ord_mem[cmd_r.slot[OW-1:0]] <= cmd_r.order;
    end
    if (ord_ren) begin
      ord_rdata_r <= ord_mem[ord_raddr[OW-1:0]];
      ord_rvld_r  <= ord_vld_r[ord_raddr[OW-1:0]]
                     && ({1'b0, ord_raddr} < 9'(ORDER_SLOTS));
    end
  end

  // A sorted slot that was never loaded reads as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        ord_vld_r[i] <= 1'b0;
      end
    end else if ((state_r == ST_LOAD) && (cmd_r.op == OP_LOAD_ORD)) begin
      ord_vld_r[cmd_r.slot[OW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fsize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_LOAD) && (cmd_r.op == OP_SET_SIZE)) begin
        fsize_r <= cmd_r.pos;
      end else if ((state_r == ST_FIN_UPD) && (cmd_r.op == OP_QUERY_WR)
                   && (count_r != '0) && (fsize_r < end_r)) begin
        fsize_r <= end_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cmd_r   <= q_cmd;
        curr_r  <= '0;
        step_r  <= FIRST_STEP;
        fsub_r  <= {1'b0, fsize_r} - {1'b0, q_cmd.pos};
        found_r <= 1'b0;
        addr_r  <= '0;
        count_r <= '0;
      end
      ST_PRB_ORD: begin
        size_r <= size_clip;
        e_r    <= ord_e;
        if (!ord_use) begin
          step_r <= step_half;
        end
      end
      ST_PRB_EXT: begin
        curr_r <= curr_adv;
        step_r <= step_half;
        if (ext_in) begin
          found_r <= 1'b1;
          spos_r  <= probe_slot;
          ext_r   <= e_r;
          diff_r  <= ext_d[LEN_W-1:0];
          len_r   <= ext_rdata_r.length;
          base_r  <= ext_rdata_r.base;
        end
      end
      ST_FIN_CNT: begin
        if (found_r && (base_r != '0)) begin
          count_r <= (avail < size_r) ? avail : size_r;
          addr_r  <= base_r + {1'b0, diff_r};
        end
      end
      ST_FIN_END: begin
        end_r <= end_sum[63] ? {POS_W{1'b1}} : end_sum[POS_W-1:0];
      end
      default: begin
        cmd_r <= cmd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= found_r;
      out_spos_r  <= found_r ? spos_r : '0;
      out_ext_r   <= found_r ? ext_r : '0;
      out_addr_r  <= addr_r;
      out_count_r <= count_r;
      out_fsize_r <= fsize_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {2'b00, out_fsize_r, out_count_r, out_addr_r, out_ext_r, out_spos_r};

endmodule

// ----- rtl/extent_map_lookup.sv -----
// ----------------------------------------------------------------------------
// extent_map_lookup
// Extent table with a sorted slot list and a binary probe for file positions.
// ----------------------------------------------------------------------------
// Input items arrive on the in_ stream, one item per accepted beat; tuser
// holds the mode (load extent, load sorted slot, set file size, read query,
// write query). Every item gives exactly one result item on the out_ stream,
// in order; tuser there is the found flag.
// A two-entry queue parts the decoding front from the table back end, so
// items are taken while the back end is busy or a result waits.
// Load and set-size items pass through the load and output states of the back
// end. A query runs up to nine probe steps: each reads the sorted table and,
// when the slot names an extent, then the extent table; the count and
// address, the end position and the new file size are then formed in turn.
// Reset empties all sorted slots and clears the file size; extent entries
// are undefined until loaded. A stalled receiver holds the result in the
// output register; the back end waits with the next result, and the input
// stops once the queue is full.
// ----------------------------------------------------------------------------
module extent_map_lookup #(
  parameter int EXTENT_ENTRIES = 240,
  parameter int ORDER_SLOTS    = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot, load_start, load_length, load_base, load_order, new_size,
  // query_pos, query_size, zero fill
  input  logic [eml_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic [eml_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sorted_pos, extent_hit, mem_address, byte_count, file_size_now, zero fill
  output logic [eml_pkg::OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic [eml_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import eml_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  eml_front #(
    .EXTENT_ENTRIES(EXTENT_ENTRIES),
    .ORDER_SLOTS   (ORDER_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  eml_back #(
    .EXTENT_ENTRIES(EXTENT_ENTRIES),
    .ORDER_SLOTS   (ORDER_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
